/* hw/rtl/egm_pkg.sv */
// Package with shared types and constants of the 3x3 gradient magnitude block.
`timescale 1ns / 1ps
package egm_pkg;
  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned PixW = 8;
  localparam int unsigned RowW = 12;
  localparam int unsigned ColW = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;

  localparam logic [1:0] ModeRoberts = 2'd0;
  localparam logic [1:0] ModePrewitt = 2'd1;
  localparam logic [1:0] ModeSobel = 2'd2;

  localparam logic [CfgIdxW-1:0] RegMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;    // accept the input word: read line stores
    logic upd;     // state after take: compute, write stores, shift window
    logic sq_ld;   // load the square root unit
    logic sq_step; // one root bit
    logic out_ld;  // move result into the output register
  } egm_cmd_t;

  typedef struct packed {
    logic emit;    // current item produces a result
    logic sq_done;
  } egm_sts_t;
endpackage

/* hw/rtl/egm_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module egm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/egm_datapath.sv */
// Datapath: counters, line stores, window, gradients, serial square root.
`timescale 1ns / 1ps
module egm_datapath import egm_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  egm_cmd_t        cmd_i,
  output egm_sts_t        sts_o,
  input  logic [PixW-1:0] pixel_i,
  input  logic            frame_start_i,
  input  logic [1:0]      mode_i,
  input  logic [10:0]     width_i,
  input  logic [11:0]     height_i,
  output logic [PixW-1:0] mag_o,
  output logic [RowW-1:0] row_o,
  output logic [ColW-1:0] col_o,
  output logic            fend_o
);
  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned CW = AW + 1;

  logic [CW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PixW-1:0] win_q [6];
  logic [PixW-1:0] px_q;
  logic [CW-1:0] c_q;
  logic [RowW-1:0] r_q;
  logic [PixW-1:0] up_rd, mid_rd;
  logic [CW-1:0] w_eff;
  logic [RowW-1:0] h_eff;
  logic [CW-1:0] c_cur;
  logic [RowW-1:0] r_cur;

  // Effective limits.
  always_comb begin
    if (width_i < 11'd3) w_eff = CW'(3);
    else if ({{(CW > 11 ? CW-11 : 0){1'b0}}, width_i} > CW'(MaxWidth)) w_eff = CW'(MaxWidth);
    else w_eff = CW'(width_i);
    h_eff = (height_i < 12'd3) ? 12'd3 : height_i;
  end

  always_comb begin
    r_cur = frame_start_i ? '0 : row_q;
    c_cur = frame_start_i ? '0 : col_q;
    if (c_cur >= CW'(MaxWidth)) c_cur = '0;
  end

  egm_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(cmd_i.upd), .waddr_i(c_q[AW-1:0]), .wdata_i(mid_rd),
    .raddr_i(c_cur[AW-1:0]), .rdata_o(up_rd));
  egm_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(cmd_i.upd), .waddr_i(c_q[AW-1:0]), .wdata_i(px_q),
    .raddr_i(c_cur[AW-1:0]), .rdata_o(mid_rd));

  logic emit_c;
  assign emit_c = (r_q >= 12'd2) && (r_q < h_eff) && (c_q >= CW'(2)) && (c_q < w_eff);
  assign sts_o.emit = emit_c;

  // Gradients from the window a b c / d e f / g h i.
  logic signed [11:0] sa, sb, sc, sd, se, sf, sg, sh, si, h1, h2;
  assign sa = 12'(win_q[0]); assign sd = 12'(win_q[1]); assign sg = 12'(win_q[2]);
  assign sb = 12'(win_q[3]); assign se = 12'(win_q[4]); assign sh = 12'(win_q[5]);
  assign sc = 12'(up_rd); assign sf = 12'(mid_rd); assign si = 12'(px_q);
  always_comb begin
    case (mode_i)
      ModeRoberts: begin
        h1 = se - sa;
        h2 = se - sc;
      end
      ModePrewitt: begin
        h1 = sg + sh + si - sa - sb - sc;
        h2 = sc + sf + si - sa - sd - sg;
      end
      default: begin
        h1 = sg + (sh <<< 1) + si - sa - (sb <<< 1) - sc;
        h2 = sc + (sf <<< 1) + si - sa - (sd <<< 1) - sg;
      end
    endcase
  end
  logic [10:0] a1, a2;
  assign a1 = h1[11] ? 11'(-h1) : 11'(h1);
  assign a2 = h2[11] ? 11'(-h2) : 11'(h2);
  logic [21:0] sq1_q, sq2_q;
  logic [22:0] sum;
  assign sum = 23'(sq1_q) + 23'(sq2_q);

  // Bit-serial square root, eight steps.
  logic [15:0] rad_q;
  logic        sat_q;
  logic [7:0]  root_q, bit_q;
  logic [7:0]  trial;
  logic [15:0] tsq;
  logic        phase_q;
  assign trial = root_q | bit_q;
  assign tsq = trial * trial;
  assign sts_o.sq_done = (bit_q == '0) && !phase_q;

  logic [RowW-1:0] orow_q;
  logic [ColW-1:0] ocol_q;
  logic            ofe_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.upd) begin
      if (c_q + CW'(1) >= w_eff) begin
        col_d = '0;
        row_d = (r_q + 12'd1 >= h_eff) ? '0 : r_q + 12'd1;
      end else begin
        col_d = c_q + CW'(1);
        row_d = r_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int k = 0; k < 6; k++) win_q[k] <= '0;
      bit_q <= '0;
      phase_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.upd) begin
        win_q[0] <= win_q[3]; win_q[1] <= win_q[4]; win_q[2] <= win_q[5];
        win_q[3] <= up_rd; win_q[4] <= mid_rd; win_q[5] <= px_q;
      end
      if (cmd_i.upd && emit_c) begin
        phase_q <= 1'b1;
      end else if (cmd_i.sq_ld) begin
        phase_q <= 1'b0;
        bit_q <= 8'h80;
      end else if (cmd_i.sq_step && bit_q != '0) begin
        bit_q <= bit_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      px_q <= pixel_i;
      c_q <= c_cur;
      r_q <= r_cur;
    end
    if (cmd_i.upd) begin
      sq1_q <= a1 * a1;
      sq2_q <= a2 * a2;
      orow_q <= r_q - 12'd1;
      ocol_q <= ColW'(c_q - CW'(1));
      ofe_q <= (r_q == h_eff - 12'd1) && (c_q == w_eff - CW'(1));
    end
    if (cmd_i.sq_ld) begin
      rad_q <= sum[15:0];
      sat_q <= sum[22:16] != '0;
      root_q <= '0;
    end else if (cmd_i.sq_step && bit_q != '0) begin
      if (tsq <= rad_q) root_q <= trial;
    end
    if (cmd_i.out_ld) begin
      mag_o <= sat_q ? 8'hFF : root_q;
      row_o <= orow_q;
      col_o <= ocol_q;
      fend_o <= ofe_q;
    end
  end
endmodule

/* hw/rtl/egm_ctrl.sv */
// Controller state machine sequencing one word through the datapath.
`timescale 1ns / 1ps
module egm_ctrl import egm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output egm_cmd_t cmd_o,
  input  egm_sts_t sts_i
);
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StUpd  = 4'b0010,
    StLoad = 4'b0100,
    StRoot = 4'b1000
  } state_e;
  state_e state_q, state_d;
  logic ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = StUpd;
        end
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d = sts_i.emit ? StLoad : StIdle;
      end
      StLoad: begin
        cmd_o.sq_ld = 1'b1;
        state_d = StRoot;
      end
      StRoot: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_done && !ov_d) begin
          cmd_o.out_ld = 1'b1;
          ov_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end
  assign out_valid_o = ov_q;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_load_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !ov_q || out_ready_i) else $error("result overwritten");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == StUpd) else $error("take without update");
endmodule

/* hw/rtl/edge_gradient_magnitude_3x3.sv */
// Top level of the streaming 3x3 gradient magnitude edge detector.
`timescale 1ns / 1ps
// Usage: grey pixels enter in raster order on the s_axis channel, one word
// each, with tuser carrying frame_start (restarts row and column at zero).
// The cfg port writes operator_mode (index 0), image_width (1) and
// image_height (2); the user must write them only while the block is idle, which
// the block itself does not enforce; values apply at once. For every pixel whose
// 3x3 window covers an interior centre, one word leaves on m_axis with the saturated
// floor of sqrt(h1*h1+h2*h2), the centre row and column, and tlast set on the last interior result of a frame.
// A pixel that gives no result passes only the take and update steps; one that
// gives a result goes through all steps (read line stores, form gradients and
// squares, load the bit-serial square root unit, eight root steps, then the
// output register). A new pixel is taken only once the previous one is done.
// The output register holds one result; while it is full and the receiver
// stalls, the next pixel is still taken and processed up to the root, where
// the controller waits for the register to empty.
// Reset clears counters, window and handshake state; the line stores are not
// cleared and are only read at places already written for interior results.
module edge_gradient_magnitude_3x3 import egm_pkg::*; #(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
  input  logic                s_axis_tuser,   // [0] frame_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [7:0] magnitude, [19:8] centre_row,
                                              // [29:20] centre_col, zeros above
  output logic                m_axis_tlast,   // frame_end
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [1:0]  mode_q;
  logic [10:0] width_q;
  logic [11:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeSobel;
      width_q <= 11'd640;
      height_q <= 12'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   mode_q <= cfg_data_i[1:0];
        RegWidth:  width_q <= cfg_data_i[10:0];
        RegHeight: height_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  egm_cmd_t cmd;
  egm_sts_t sts;
  logic [PixW-1:0] mag;
  logic [RowW-1:0] row;
  logic [ColW-1:0] col;

  egm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .sts_i(sts));

  egm_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .pixel_i(s_axis_tdata), .frame_start_i(s_axis_tuser),
    .mode_i(mode_q), .width_i(width_q), .height_i(height_q),
    .mag_o(mag), .row_o(row), .col_o(col), .fend_o(m_axis_tlast));

  assign m_axis_tdata = {2'b00, col, row, mag};
endmodule
